// File: rtl/mrrm_pkg.sv
package mrrm_pkg;

  // Longest response frame that is stored; longer frames are flagged invalid.
  localparam int unsigned MAX_FRAME = 255;
  localparam int unsigned POS_W     = $clog2(MAX_FRAME + 1);
  localparam int unsigned IDX_W     = POS_W - 1;

  localparam int unsigned REQ_BYTES = 8;
  localparam int unsigned CNT_W     = $clog2(REQ_BYTES);

  localparam logic [7:0]  FUNC_HOLDING = 8'h03;
  localparam logic [7:0]  FUNC_INPUT   = 8'h04;
  localparam logic [7:0]  EXC_FLAG     = 8'h80;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;

  typedef enum logic [1:0] {
    CMD_START    = 2'd0,
    CMD_RX_BYTE  = 2'd1,
    CMD_TIMEOUT  = 2'd2,
    CMD_LINE_ERR = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_TX     = 2'd0,
    KIND_REG    = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_TIMEOUT  = 3'd1,
    ST_LINE_ERR = 3'd2,
    ST_INVALID  = 3'd3,
    ST_CRC_ERR  = 3'd4,
    ST_EXCEPT   = 3'd5
  } status_e;

  // One byte through the reflected CRC-16, LSB first.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: rtl/modbus_rtu_read_master_core.sv
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i / in_stall_o  cmd, slave_addr, use_input_regs, start_address,
//                                              reg_quantity, rx_byte, frame_end
// out      output     out_valid_o / out_stall_i kind, tx_byte, reg_value, reg_index, status, last
//
// The result (if any) of a received byte, timeout or line error sits in the output register
// the next cycle, and the next item is accepted in the cycle it is taken. A start item gives
// an eight-byte burst from the output register, one byte per cycle unless out is stalled;
// the request CRC is folded in as bytes leave, so input stalls until the last byte is taken.
// Reset clears the transaction, output valid, kind and count; out stalls lose no item.
module modbus_rtu_read_master_core
  import mrrm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  slave_addr_i,
  input  logic        use_input_regs_i,
  input  logic [15:0] start_address_i,
  input  logic [15:0] reg_quantity_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  tx_byte_o,
  output logic [15:0] reg_value_o,
  output logic [15:0] reg_index_o,
  output logic [2:0]  status_o,
  output logic        last_o
);

  // transaction state
  logic             busy_q, busy_d;
  logic [7:0]       want_slave_q, want_slave_d;
  logic [7:0]       want_func_q, want_func_d;
  logic [15:0]      want_qty_q, want_qty_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [15:0]      crc_q, crc_d;
  logic [15:0]      held_q, held_d;
  logic [23:0]      hdr_q, hdr_d;

  // output register
  logic             out_valid_q, out_valid_d;
  kind_e            kind_q, kind_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [47:0]      req_q, req_d;
  logic [15:0]      tx_crc_q, tx_crc_d;
  logic [15:0]      val_q, val_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  status_e          status_q, status_d;

  logic             accept, out_take, burst_done;
  logic             in_frame, emit_reg;
  logic [15:0]      crc_upd;
  logic [23:0]      hdr_upd;
  logic [IDX_W-1:0] idx;
  logic [15:0]      rx_crc;
  logic [7:0]       hs, hf, hc;
  logic [9:0]       len;
  status_e          end_st;
  logic [7:0]       func;

  assign out_take   = out_valid_q && !out_stall_i;
  assign burst_done = (kind_q != KIND_TX) || (cnt_q == CNT_W'(REQ_BYTES - 1));
  assign in_stall_o = out_valid_q && !(out_take && burst_done);
  assign accept     = in_valid_i && !in_stall_o;

  // received-byte datapath
  always_comb begin
    in_frame = pos_q < POS_W'(MAX_FRAME);
    crc_upd  = (pos_q >= POS_W'(2)) ? crc_feed(crc_q, held_q[15:8]) : crc_q;
    hdr_upd  = hdr_q;
    if (pos_q == POS_W'(0)) begin
      hdr_upd[23:16] = rx_byte_i;
    end else if (pos_q == POS_W'(1)) begin
      hdr_upd[15:8] = rx_byte_i;
    end else if (pos_q == POS_W'(2)) begin
      hdr_upd[7:0] = rx_byte_i;
    end
    idx      = IDX_W'((pos_q - POS_W'(4)) >> 1);
    emit_reg = in_frame && !frame_end_i && (pos_q >= POS_W'(4)) && !pos_q[0] &&
               (16'(idx) < want_qty_q);
    rx_crc   = {rx_byte_i, held_q[7:0]};
    hs       = hdr_upd[23:16];
    hf       = hdr_upd[15:8];
    hc       = hdr_upd[7:0];
    len      = 10'(pos_q) + 10'd1;
    priority if (!in_frame || pos_q < POS_W'(4)) begin
      end_st = ST_INVALID;
    end else if (rx_crc != crc_upd) begin
      end_st = ST_CRC_ERR;
    end else if (hs != want_slave_q) begin
      end_st = ST_INVALID;
    end else if (hf == (want_func_q | EXC_FLAG)) begin
      end_st = ST_EXCEPT;
    end else if (hf != want_func_q) begin
      end_st = ST_INVALID;
    end else if ({9'd0, hc} != {want_qty_q, 1'b0}) begin
      end_st = ST_INVALID;
    end else if (len != 10'(hc) + 10'd5) begin
      end_st = ST_INVALID;
    end else begin
      end_st = ST_OK;
    end
  end

  assign func = use_input_regs_i ? FUNC_INPUT : FUNC_HOLDING;

  always_comb begin
    busy_d       = busy_q;
    want_slave_d = want_slave_q;
    want_func_d  = want_func_q;
    want_qty_d   = want_qty_q;
    pos_d        = pos_q;
    crc_d        = crc_q;
    held_d       = held_q;
    hdr_d        = hdr_q;
    out_valid_d  = out_valid_q;
    kind_d       = kind_q;
    cnt_d        = cnt_q;
    req_d        = req_q;
    tx_crc_d     = tx_crc_q;
    val_d        = val_q;
    idx_d        = idx_q;
    status_d     = status_q;

    // drain: either retire the result or step the request burst
    if (out_take) begin
      if (burst_done) begin
        out_valid_d = 1'b0;
      end else begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q < CNT_W'(REQ_BYTES - 2)) begin
          tx_crc_d = crc_feed(tx_crc_q, req_q[47:40]);
          req_d    = req_q << 8;
        end
      end
    end

    if (accept) begin
      unique case (cmd_e'(cmd_i))
        CMD_START: begin
          busy_d       = 1'b1;
          want_slave_d = slave_addr_i;
          want_func_d  = func;
          want_qty_d   = reg_quantity_i;
          pos_d        = '0;
          crc_d        = CRC_INIT;
          held_d       = '0;
          hdr_d        = '0;
          out_valid_d  = 1'b1;
          kind_d       = KIND_TX;
          cnt_d        = '0;
          req_d        = {slave_addr_i, func, start_address_i, reg_quantity_i};
          tx_crc_d     = CRC_INIT;
        end
        CMD_TIMEOUT, CMD_LINE_ERR: begin
          if (busy_q) begin
            busy_d      = 1'b0;
            out_valid_d = 1'b1;
            kind_d      = KIND_STATUS;
            cnt_d       = '0;
            status_d    = (cmd_e'(cmd_i) == CMD_TIMEOUT) ? ST_TIMEOUT : ST_LINE_ERR;
          end
        end
        CMD_RX_BYTE: begin
          if (busy_q) begin
            if (in_frame) begin
              crc_d  = crc_upd;
              hdr_d  = hdr_upd;
              held_d = {held_q[7:0], rx_byte_i};
              pos_d  = pos_q + POS_W'(1);
            end
            if (emit_reg) begin
              out_valid_d = 1'b1;
              kind_d      = KIND_REG;
              cnt_d       = '0;
              val_d       = {held_q[7:0], rx_byte_i};
              idx_d       = idx;
            end else if (frame_end_i) begin
              busy_d      = 1'b0;
              out_valid_d = 1'b1;
              kind_d      = KIND_STATUS;
              cnt_d       = '0;
              status_d    = end_st;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      want_slave_q <= '0;
      want_func_q  <= '0;
      want_qty_q   <= '0;
      pos_q        <= '0;
      crc_q        <= CRC_INIT;
      held_q       <= '0;
      hdr_q        <= '0;
      out_valid_q  <= 1'b0;
      kind_q       <= KIND_TX;
      cnt_q        <= '0;
    end else begin
      busy_q       <= busy_d;
      want_slave_q <= want_slave_d;
      want_func_q  <= want_func_d;
      want_qty_q   <= want_qty_d;
      pos_q        <= pos_d;
      crc_q        <= crc_d;
      held_q       <= held_d;
      hdr_q        <= hdr_d;
      out_valid_q  <= out_valid_d;
      kind_q       <= kind_d;
      cnt_q        <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    tx_crc_q <= tx_crc_d;
    val_q    <= val_d;
    idx_q    <= idx_d;
    status_q <= status_d;
  end

  // result fields, zero where the kind does not use them
  always_comb begin
    tx_byte_o   = '0;
    reg_value_o = '0;
    reg_index_o = '0;
    status_o    = '0;
    last_o      = 1'b0;
    unique case (kind_q)
      KIND_TX: begin
        if (cnt_q < CNT_W'(REQ_BYTES - 2)) begin
          tx_byte_o = req_q[47:40];
        end else if (cnt_q == CNT_W'(REQ_BYTES - 2)) begin
          tx_byte_o = tx_crc_q[7:0];
        end else begin
          tx_byte_o = tx_crc_q[15:8];
        end
        last_o = (cnt_q == CNT_W'(REQ_BYTES - 1));
      end
      KIND_REG: begin
        reg_value_o = val_q;
        reg_index_o = 16'(idx_q);
      end
      KIND_STATUS: begin
        status_o = status_q;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;

  a_last_only_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> kind_o == KIND_TX)
    else $error("last flagged on a non-transmit result");

  a_start_loads_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cmd_i == CMD_START |=> out_valid_o && kind_o == KIND_TX && cnt_q == '0)
    else $error("start item did not open a request burst");

  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q != KIND_TX |-> cnt_q == '0)
    else $error("burst counter moved outside a request burst");

  a_idle_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !busy_q && cmd_i != CMD_START |=> !out_valid_o)
    else $error("result produced for an item while idle");

endmodule

// File: tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mrrm_pkg::*;

  localparam int RAND_ITEMS  = 300;
  localparam int DIR_ROWS    = 25;
  localparam int QUIET_LIMIT = 500;
  localparam int DRAIN       = 20;

  typedef enum logic [1:0] {
    EXP_MODEL,
    EXP_NONE,
    EXP_STATUS
  } exp_e;

  typedef enum logic [1:0] {
    RX_RAW,
    RX_CRC_LO,
    RX_CRC_HI
  } rx_src_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  slave;
    logic        use_in;
    logic [15:0] addr;
    logic [15:0] qty;
    logic [7:0]  rx;
    logic        fe;
  } req_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  tx;
    logic [15:0] value;
    logic [15:0] index;
    status_e     status;
    logic        last;
  } result_t;

  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  slave;
    logic        use_in;
    logic [15:0] addr;
    logic [15:0] qty;
    logic [7:0]  rx;
    logic        fe;
    exp_e        how;
    status_e     st;
    rx_src_e     src;
  } step_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  cmd_i;
  logic [7:0]  slave_addr_i;
  logic        use_input_regs_i;
  logic [15:0] start_address_i;
  logic [15:0] reg_quantity_i;
  logic [7:0]  rx_byte_i;
  logic        frame_end_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  kind_o;
  logic [7:0]  tx_byte_o;
  logic [15:0] reg_value_o;
  logic [15:0] reg_index_o;
  logic [2:0]  status_o;
  logic        last_o;

  modbus_rtu_read_master_core u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cmd_i            (cmd_i),
    .slave_addr_i     (slave_addr_i),
    .use_input_regs_i (use_input_regs_i),
    .start_address_i  (start_address_i),
    .reg_quantity_i   (reg_quantity_i),
    .rx_byte_i        (rx_byte_i),
    .frame_end_i      (frame_end_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .tx_byte_o        (tx_byte_o),
    .reg_value_o      (reg_value_o),
    .reg_index_o      (reg_index_o),
    .status_o         (status_o),
    .last_o           (last_o)
  );

  // Directed items. Response CRC bytes are filled in from the bytes sent so far.
  step_row_t dir_tab [DIR_ROWS] = '{
    '{CMD_RX_BYTE,  8'h00, 1'b0, 16'h0000, 16'h0000, 8'hFF, 1'b1, EXP_NONE,   ST_OK, RX_RAW},
    '{CMD_TIMEOUT,  8'h00, 1'b0, 16'h0000, 16'h0000, 8'h00, 1'b0, EXP_NONE,   ST_OK, RX_RAW},
    '{CMD_LINE_ERR, 8'h00, 1'b0, 16'h0000, 16'h0000, 8'h00, 1'b0, EXP_NONE,   ST_OK, RX_RAW},
    '{CMD_START,    8'h00, 1'b0, 16'h0000, 16'h0000, 8'h00, 1'b0, EXP_MODEL,  ST_OK, RX_RAW},
    '{CMD_TIMEOUT,  8'h00, 1'b0, 16'h0000, 16'h0000, 8'h00, 1'b0, EXP_STATUS, ST_TIMEOUT,
      RX_RAW},
    '{CMD_START,    8'hFF, 1'b1, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, EXP_MODEL,  ST_OK, RX_RAW},
    '{CMD_LINE_ERR, 8'h00, 1'b0, 16'h0000, 16'h0000, 8'h00, 1'b0, EXP_STATUS, ST_LINE_ERR,
      RX_RAW},
    '{CMD_START,    8'h11, 1'b0, 16'h006B, 16'h0001, 8'h00, 1'b0, EXP_MODEL,  ST_OK, RX_RAW},
    '{CMD_RX_BYTE,  8'h00, 1'b0, 16'h0000, 16'h0000, 8'h11, 1'b0, EXP_MODEL,  ST_OK, RX_RAW},
    '{CMD_RX_BYTE,  8'h00, 1'b0, 16'h0000, 16'h0000, 8'h03, 1'b0, EXP_MODEL,  ST_OK, RX_RAW},
    '{CMD_RX_BYTE,  8'h00, 1'b0, 16'h0000, 16'h0000, 8'h02, 1'b0, EXP_MODEL,  ST_OK, RX_RAW},
    '{CMD_RX_BYTE,  8'h00, 1'b0, 16'h0000, 16'h0000, 8'hAB, 1'b0, EXP_MODEL,  ST_OK, RX_RAW},
    '{CMD_RX_BYTE,  8'h00, 1'b0, 16'h0000, 16'h0000, 8'hCD, 1'b0, EXP_MODEL,  ST_OK, RX_RAW},
    '{CMD_RX_BYTE,  8'h00, 1'b0, 16'h0000, 16'h0000, 8'h00, 1'b0, EXP_MODEL,  ST_OK, RX_CRC_LO},
    '{CMD_RX_BYTE,  8'h00, 1'b0, 16'h0000, 16'h0000, 8'h00, 1'b1, EXP_MODEL,  ST_OK, RX_CRC_HI},
    '{CMD_START,    8'h11, 1'b0, 16'h0000, 16'h0002, 8'h00, 1'b0, EXP_MODEL,  ST_OK, RX_RAW},
    '{CMD_RX_BYTE,  8'h00, 1'b0, 16'h0000, 16'h0000, 8'h11, 1'b0, EXP_MODEL,  ST_OK, RX_RAW},
    '{CMD_RX_BYTE,  8'h00, 1'b0, 16'h0000, 16'h0000, 8'h83, 1'b0, EXP_MODEL,  ST_OK, RX_RAW},
    '{CMD_RX_BYTE,  8'h00, 1'b0, 16'h0000, 16'h0000, 8'h02, 1'b0, EXP_MODEL,  ST_OK, RX_RAW},
    '{CMD_RX_BYTE,  8'h00, 1'b0, 16'h0000, 16'h0000, 8'h00, 1'b0, EXP_MODEL,  ST_OK, RX_CRC_LO},
    '{CMD_RX_BYTE,  8'h00, 1'b0, 16'h0000, 16'h0000, 8'h00, 1'b1, EXP_STATUS, ST_EXCEPT,
      RX_CRC_HI},
    '{CMD_START,    8'hA5, 1'b1, 16'h1234, 16'h0003, 8'h00, 1'b0, EXP_MODEL,  ST_OK, RX_RAW},
    '{CMD_RX_BYTE,  8'h00, 1'b0, 16'h0000, 16'h0000, 8'hA5, 1'b0, EXP_MODEL,  ST_OK, RX_RAW},
    // restart while a response is still coming in
    '{CMD_START,    8'h01, 1'b0, 16'hFFFF, 16'h0001, 8'h00, 1'b0, EXP_MODEL,  ST_OK, RX_RAW},
    '{CMD_RX_BYTE,  8'h00, 1'b0, 16'h0000, 16'h0000, 8'h01, 1'b1, EXP_STATUS, ST_INVALID,
      RX_RAW}
  };

  // Master state as the predictor sees it
  logic        mb_busy    = 1'b0;
  logic [7:0]  want_slave = '0;
  logic [7:0]  want_func  = '0;
  logic [15:0] want_qty   = '0;
  int          rx_pos     = 0;
  logic [15:0] run_crc    = CRC_INIT;
  logic [15:0] held       = '0;
  logic [23:0] hdr        = '0;

  result_t step_results[$];
  result_t due_results[$];
  result_t seen, due;

  int fails        = 0;
  int item_count   = 0;
  int quiet_cycles = 0;
  bit in_calm      = 1'b0;
  bit out_calm     = 1'b0;

  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ b[i]) r = (r >> 1) ^ CRC_POLY;
      else r = r >> 1;
    end
    return r;
  endfunction

  // Works out the results of one accepted item into step_results.
  function automatic void master_step(input req_t r);
    logic [7:0]  req_bytes [REQ_BYTES];
    logic [15:0] c;
    logic [15:0] prev;
    logic [15:0] rx_crc;
    int          p;
    int          len;
    int          idx;
    result_t     res;
    status_e     st;
    step_results.delete();
    res = '0;
    if (r.cmd == CMD_START) begin
      req_bytes[0] = r.slave;
      req_bytes[1] = r.use_in ? FUNC_INPUT : FUNC_HOLDING;
      req_bytes[2] = r.addr[15:8];
      req_bytes[3] = r.addr[7:0];
      req_bytes[4] = r.qty[15:8];
      req_bytes[5] = r.qty[7:0];
      c = CRC_INIT;
      for (int i = 0; i < 6; i++) c = crc16_step(c, req_bytes[i]);
      req_bytes[6] = c[7:0];
      req_bytes[7] = c[15:8];
      for (int i = 0; i < REQ_BYTES; i++) begin
        res = '0;
        res.kind = KIND_TX;
        res.tx = req_bytes[i];
        res.last = (i == REQ_BYTES - 1);
        step_results = {step_results, res};
      end
      mb_busy = 1'b1;
      want_slave = req_bytes[0];
      want_func = req_bytes[1];
      want_qty = r.qty;
      rx_pos = 0;
      run_crc = CRC_INIT;
      held = '0;
      hdr = '0;
      return;
    end
    if (!mb_busy) return;
    if (r.cmd != CMD_RX_BYTE) begin
      mb_busy = 1'b0;
      res.kind = KIND_STATUS;
      res.status = (r.cmd == CMD_TIMEOUT) ? ST_TIMEOUT : ST_LINE_ERR;
      step_results = {step_results, res};
      return;
    end
    p = rx_pos;
    prev = held;
    rx_crc = '0;
    // bytes past the frame limit are dropped but still end the frame
    if (p < MAX_FRAME) begin
      if (p >= 2) run_crc = crc16_step(run_crc, prev[15:8]);
      case (p)
        0: hdr[23:16] = r.rx;
        1: hdr[15:8] = r.rx;
        2: hdr[7:0] = r.rx;
        default: ;
      endcase
      if (!r.fe && p >= 4 && (p % 2) == 0) begin
        idx = (p - 4) / 2;
        if (idx < int'(want_qty)) begin
          res = '0;
          res.kind = KIND_REG;
          res.value = {prev[7:0], r.rx};
          res.index = 16'(idx);
          step_results = {step_results, res};
        end
      end
      rx_crc = {r.rx, prev[7:0]};
      held = {prev[7:0], r.rx};
      rx_pos = p + 1;
    end
    if (r.fe) begin
      len = p + 1;
      if (p >= MAX_FRAME || len < 5) st = ST_INVALID;
      else if (rx_crc != run_crc) st = ST_CRC_ERR;
      else if (hdr[23:16] != want_slave) st = ST_INVALID;
      else if (hdr[15:8] == (want_func | EXC_FLAG)) st = ST_EXCEPT;
      else if (hdr[15:8] != want_func) st = ST_INVALID;
      else if (int'(hdr[7:0]) != 2 * int'(want_qty)) st = ST_INVALID;
      else if (len != 5 + int'(hdr[7:0])) st = ST_INVALID;
      else st = ST_OK;
      mb_busy = 1'b0;
      res = '0;
      res.kind = KIND_STATUS;
      res.status = st;
      step_results = {step_results, res};
    end
  endfunction

  function automatic req_t rand_req();
    req_t r;
    r.cmd = cmd_e'($urandom_range(0, 3));
    r.slave = 8'($urandom);
    r.use_in = 1'($urandom);
    r.addr = 16'($urandom);
    r.qty = 16'($urandom);
    r.rx = 8'($urandom);
    r.fe = 1'($urandom);
    return r;
  endfunction

  // Entered and left at a falling edge.
  task automatic send(input req_t r, input exp_e how, input status_e st, input bit counts);
    int      gap;
    result_t res;
    if ($urandom_range(0, 31) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : int'($urandom_range(0, 3));
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_i = r.cmd;
    slave_addr_i = r.slave;
    use_input_regs_i = r.use_in;
    start_address_i = r.addr;
    reg_quantity_i = r.qty;
    rx_byte_i = r.rx;
    frame_end_i = r.fe;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    master_step(r);
    case (how)
      EXP_MODEL: begin
        due_results = {due_results, step_results};
      end
      EXP_STATUS: begin
        res = '0;
        res.kind = KIND_STATUS;
        res.status = st;
        due_results = {due_results, res};
      end
      default: ;
    endcase
    if (counts) item_count++;
    @(negedge clk_i);
  endtask

  task automatic run_transaction(input int tx_no);
    req_t        r;
    logic [7:0]  frame[$];
    logic [7:0]  fn;
    logic [15:0] qty;
    logic [15:0] c;
    int          scen;
    int          nb;
    int          cut;
    int          pos;
    bit          counts;
    // noise while idle, ignored by the block
    if (!mb_busy && $urandom_range(0, 5) == 0) begin
      r = rand_req();
      r.cmd = cmd_e'($urandom_range(1, 3));
      send(r, EXP_MODEL, ST_OK, 1'b0);
    end
    scen = $urandom_range(0, 19);
    counts = 1'b1;
    qty = 16'($urandom_range(0, 6));
    if ($urandom_range(0, 7) == 0) qty = 16'($urandom_range(0, 125));
    if (scen >= 11 && $urandom_range(0, 2) == 0) qty = 16'($urandom);
    // one frame of the longest legal size, or one byte past the limit
    if (tx_no == 2) begin
      scen = 0;
      qty = 16'd125;
    end
    nb = (qty <= 16'd126) ? 2 * int'(qty) : int'($urandom_range(0, 16));

    r = rand_req();
    r.cmd = CMD_START;
    r.qty = qty;
    send(r, EXP_MODEL, ST_OK, counts);

    fn = r.use_in ? FUNC_INPUT : FUNC_HOLDING;
    frame = {r.slave, fn, 8'(nb)};
    repeat (nb) frame = {frame, 8'($urandom)};
    case (scen)
      11: frame[0] ^= 8'(1 << $urandom_range(0, 7));
      12: frame = {r.slave, fn | EXC_FLAG, 8'($urandom)};
      13: frame[1] ^= 8'(1 << $urandom_range(0, 6));
      14: frame[2] ^= 8'(1 << $urandom_range(0, 7));
      15: begin
        if (nb > 0 && $urandom_range(0, 1) == 0) frame.pop_back();
        else frame = {frame, 8'($urandom)};
      end
      17: begin
        frame.delete();
        repeat ($urandom_range(1, 10)) frame = {frame, 8'($urandom)};
      end
      default: ;
    endcase
    if (scen != 17) begin
      c = CRC_INIT;
      foreach (frame[i]) c = crc16_step(c, frame[i]);
      frame = {frame, c[7:0], c[15:8]};
    end
    if (tx_no == 2 && $urandom_range(0, 1) == 0) frame = {frame, 8'($urandom)};
    if (scen == 16) begin
      pos = $urandom_range(0, frame.size() - 1);
      frame[pos] ^= 8'(1 << $urandom_range(0, 7));
    end
    cut = frame.size();
    if (scen == 18 || scen == 19) cut = $urandom_range(0, frame.size() - 1);
    for (int i = 0; i < cut; i++) begin
      r = rand_req();
      r.cmd = CMD_RX_BYTE;
      r.rx = frame[i];
      r.fe = (i == frame.size() - 1);
      send(r, EXP_MODEL, ST_OK, counts);
    end
    // a cut-off frame either aborts or is left for the next start to drop
    if (scen == 18) begin
      r = rand_req();
      r.cmd = $urandom_range(0, 1) ? CMD_TIMEOUT : CMD_LINE_ERR;
      send(r, EXP_MODEL, ST_OK, counts);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: each result waits a random number of stalled cycles first.
  initial begin
    int hold;
    out_stall_i = 1'b0;
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 31) == 0) out_calm = !out_calm;
      hold = out_calm ? 0 : int'($urandom_range(0, 3));
      if (hold > 0) begin
        out_stall_i = 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (out_valid_o && !out_stall_i) begin
        seen.kind = kind_e'(kind_o);
        seen.tx = tx_byte_o;
        seen.value = reg_value_o;
        seen.index = reg_index_o;
        seen.status = status_e'(status_o);
        seen.last = last_o;
        if (due_results.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected result: kind %0d tx %02h val %04h idx %0d st %0d last %0d",
                     seen.kind, seen.tx, seen.value, seen.index, seen.status, seen.last);
        end else begin
          due = due_results.pop_front();
          if (seen !== due) begin
            fails++;
            if (fails <= 10)
              $display({"mismatch: want kind %0d tx %02h val %04h idx %0d st %0d last %0d,",
                        " got kind %0d tx %02h val %04h idx %0d st %0d last %0d"},
                       due.kind, due.tx, due.value, due.index, due.status, due.last,
                       seen.kind, seen.tx, seen.value, seen.index, seen.status, seen.last);
          end
        end
      end
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    req_t        r;
    step_row_t   row;
    logic [15:0] dir_crc;
    int          tx_no;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    cmd_i = CMD_START;
    slave_addr_i = '0;
    use_input_regs_i = 1'b0;
    start_address_i = '0;
    reg_quantity_i = '0;
    rx_byte_i = '0;
    frame_end_i = 1'b0;
    dir_crc = CRC_INIT;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int k = 0; k < DIR_ROWS; k++) begin
      row = dir_tab[k];
      r.cmd = row.cmd;
      r.slave = row.slave;
      r.use_in = row.use_in;
      r.addr = row.addr;
      r.qty = row.qty;
      r.rx = row.rx;
      r.fe = row.fe;
      if (row.cmd == CMD_START) dir_crc = CRC_INIT;
      else if (row.cmd == CMD_RX_BYTE) begin
        case (row.src)
          RX_CRC_LO: r.rx = dir_crc[7:0];
          RX_CRC_HI: r.rx = dir_crc[15:8];
          default: dir_crc = crc16_step(dir_crc, row.rx);
        endcase
      end
      send(r, row.how, row.st, 1'b0);
    end

    tx_no = 0;
    while (item_count < RAND_ITEMS) begin
      run_transaction(tx_no);
      tx_no++;
    end
    in_valid_i = 1'b0;

    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (fails == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// File: files.f
rtl/mrrm_pkg.sv
rtl/modbus_rtu_read_master_core.sv
tb/sv/tb.sv
